// ===== src/assert_macros.svh =====
// Assertion helpers, clocked on clock, disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle.
`define RC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define RC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/rotenc_pkg.sv =====
package rotenc_pkg;

   localparam int ROT_MAX    = 7;
   localparam int ROT_W      = 3;
   localparam int BTN_MAX    = 10000;
   localparam int BTN_W      = 14;
   localparam int POS_W      = 16;
   localparam int CNT_W      = 8;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_LOW_LIMIT  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_LIMIT = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_WRAP = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_WRAP  = 8'd3;

   typedef enum logic [1:0] {
      STEP_NONE    = 2'd0,
      STEP_UP      = 2'd1,
      STEP_DOWN    = 2'd2,
      STEP_BLOCKED = 2'd3
   } step_type;

   typedef struct packed {
      logic signed [POS_W-1:0] low_limit;
      logic signed [POS_W-1:0] high_limit;
      logic [CNT_W-1:0]        short_wrap;
      logic [CNT_W-1:0]        long_wrap;
   } cfg_type;

   typedef struct packed {
      logic signed [POS_W-1:0] position_value;
      logic [CNT_W-1:0]        short_press_count;
      logic [CNT_W-1:0]        long_press_count;
      step_type                step_event;
      logic                    short_press_event;
      logic                    long_press_event;
      logic                    button_raw_pressed;
   } rsp_word_type;

endpackage

// ===== src/rotenc_if.sv =====
interface rotenc_req_if;
   logic                               valid;
   logic                               ready;
   logic                               req_type;
   logic                               pin_left;
   logic                               pin_right;
   logic                               pin_button;
   logic signed [rotenc_pkg::POS_W-1:0] load_value;

   modport source(output valid, req_type, pin_left, pin_right, pin_button, load_value,
                  input ready);
   modport sink(input valid, req_type, pin_left, pin_right, pin_button, load_value,
                output ready);
endinterface

interface rotenc_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [rotenc_pkg::POS_W-1:0] position_value;
   logic [rotenc_pkg::CNT_W-1:0]        short_press_count;
   logic [rotenc_pkg::CNT_W-1:0]        long_press_count;
   logic [1:0]                          step_event;
   logic                                short_press_event;
   logic                                long_press_event;
   logic                                button_raw_pressed;

   modport source(output valid, position_value, short_press_count, long_press_count,
                  step_event, short_press_event, long_press_event, button_raw_pressed,
                  input ready);
   modport sink(input valid, position_value, short_press_count, long_press_count,
                step_event, short_press_event, long_press_event, button_raw_pressed,
                output ready);
endinterface

interface rotenc_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [rotenc_pkg::CSR_IDX_W-1:0]     index;
   logic [rotenc_pkg::CSR_DATA_W-1:0]    wdata;

   modport source(output valid, index, wdata, input ready);
   modport sink(input valid, index, wdata, output ready);
endinterface

// ===== src/rotenc_csr.sv =====
module rotenc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                wr_valid,
   input  logic [rotenc_pkg::CSR_IDX_W-1:0]    wr_index,
   input  logic [rotenc_pkg::CSR_DATA_W-1:0]   wr_data,
   output logic                                wr_ready,
   output rotenc_pkg::cfg_type                 cfg
);

   rotenc_pkg::cfg_type cfg_ff;
   rotenc_pkg::cfg_type cfg_in;
   logic                wr_fire;

   assign wr_ready = !reset;
   assign wr_fire  = wr_valid && wr_ready;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_fire) begin
         case (wr_index)
            rotenc_pkg::CSR_LOW_LIMIT:  cfg_in.low_limit  = $signed(wr_data);
            rotenc_pkg::CSR_HIGH_LIMIT: cfg_in.high_limit = $signed(wr_data);
            rotenc_pkg::CSR_SHORT_WRAP: cfg_in.short_wrap = wr_data[rotenc_pkg::CNT_W-1:0];
            rotenc_pkg::CSR_LONG_WRAP:  cfg_in.long_wrap  = wr_data[rotenc_pkg::CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.low_limit  <= '0;
         cfg_ff.high_limit <= '0;
         cfg_ff.short_wrap <= rotenc_pkg::CNT_W'(1);
         cfg_ff.long_wrap  <= rotenc_pkg::CNT_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== src/rotenc_core.sv =====
module rotenc_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  logic                                req_type,
   input  logic                                pin_left,
   input  logic                                pin_right,
   input  logic                                pin_button,
   input  logic signed [rotenc_pkg::POS_W-1:0] load_value,
   input  rotenc_pkg::cfg_type                 cfg,
   output rotenc_pkg::rsp_word_type            result
);

   logic [rotenc_pkg::ROT_W-1:0]        rot_ff, rot_in;
   logic [rotenc_pkg::BTN_W-1:0]        btn_ff, btn_in;
   logic                                detent_armed_ff, detent_armed_in;
   logic                                long_armed_ff, long_armed_in;
   logic signed [rotenc_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [rotenc_pkg::CNT_W-1:0]        short_cnt_ff, short_cnt_in;
   logic [rotenc_pkg::CNT_W-1:0]        long_cnt_ff, long_cnt_in;
   rotenc_pkg::step_type                step;
   logic                                short_ev;
   logic                                long_ev;

   always_comb begin
      rot_in          = rot_ff;
      btn_in          = btn_ff;
      detent_armed_in = detent_armed_ff;
      long_armed_in   = long_armed_ff;
      pos_in          = pos_ff;
      short_cnt_in    = short_cnt_ff;
      long_cnt_in     = long_cnt_ff;
      step            = rotenc_pkg::STEP_NONE;
      short_ev        = 1'b0;
      long_ev         = 1'b0;

      if (req_type) begin
         pos_in = load_value;
      end else begin
         // rotation integrator drops by one at its top even with pin active
         if (!pin_left && rot_ff < rotenc_pkg::ROT_W'(rotenc_pkg::ROT_MAX)) begin
            rot_in = rot_ff + rotenc_pkg::ROT_W'(1);
         end else if (rot_ff != '0) begin
            rot_in = rot_ff - rotenc_pkg::ROT_W'(1);
         end

         if (!pin_button) begin
            if (btn_ff < rotenc_pkg::BTN_W'(rotenc_pkg::BTN_MAX)) begin
               btn_in = btn_ff + rotenc_pkg::BTN_W'(1);
            end
         end else if (btn_ff != '0) begin
            btn_in = btn_ff - rotenc_pkg::BTN_W'(1);
         end

         if (rot_in > rotenc_pkg::ROT_W'(rotenc_pkg::ROT_MAX - 2) && !detent_armed_ff) begin
            detent_armed_in = 1'b1;
            if (!pin_right && $signed(pos_ff) < $signed(cfg.high_limit)) begin
               pos_in = pos_ff + rotenc_pkg::POS_W'(1);
               step   = rotenc_pkg::STEP_UP;
            end else if (pin_right && $signed(pos_ff) > $signed(cfg.low_limit)) begin
               pos_in = pos_ff - rotenc_pkg::POS_W'(1);
               step   = rotenc_pkg::STEP_DOWN;
            end else begin
               step = rotenc_pkg::STEP_BLOCKED;
            end
         end

         if (rot_in == '0 && btn_in == '0) begin
            detent_armed_in = 1'b0;
            long_armed_in   = 1'b0;
         end

         if (btn_in > rotenc_pkg::BTN_W'(rotenc_pkg::BTN_MAX - 2) && !long_armed_in) begin
            long_armed_in = 1'b1;
            long_ev       = 1'b1;
            long_cnt_in   = (long_cnt_ff < cfg.long_wrap) ?
                            long_cnt_ff + rotenc_pkg::CNT_W'(1) : '0;
         end

         // short press shares the detent flag
         if (btn_in > rotenc_pkg::BTN_W'(rotenc_pkg::ROT_MAX - 2) && !detent_armed_in) begin
            detent_armed_in = 1'b1;
            short_ev        = 1'b1;
            short_cnt_in    = (short_cnt_ff < cfg.short_wrap) ?
                              short_cnt_ff + rotenc_pkg::CNT_W'(1) : '0;
         end
      end
   end

   always_comb begin
      result.position_value     = pos_in;
      result.short_press_count  = short_cnt_in;
      result.long_press_count   = long_cnt_in;
      result.step_event         = step;
      result.short_press_event  = short_ev;
      result.long_press_event   = long_ev;
      result.button_raw_pressed = !pin_button;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_ff          <= '0;
         btn_ff          <= '0;
         detent_armed_ff <= 1'b0;
         long_armed_ff   <= 1'b0;
         pos_ff          <= '0;
         short_cnt_ff    <= '0;
         long_cnt_ff     <= '0;
      end else if (accept) begin
         rot_ff          <= rot_in;
         btn_ff          <= btn_in;
         detent_armed_ff <= detent_armed_in;
         long_armed_ff   <= long_armed_in;
         pos_ff          <= pos_in;
         short_cnt_ff    <= short_cnt_in;
         long_cnt_ff     <= long_cnt_in;
      end
   end

endmodule

// ===== src/rotenc_out.sv =====
module rotenc_out (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  rotenc_pkg::rsp_word_type  word_in,
   output logic                      out_valid,
   input  logic                      out_ready,
   output rotenc_pkg::rsp_word_type  word_out,
   output logic                      accept
);

   logic                     valid_ff, valid_in;
   rotenc_pkg::rsp_word_type word_ff;

   assign in_ready  = !reset && (!valid_ff || out_ready);
   assign accept    = in_valid && in_ready;
   assign valid_in  = accept || (valid_ff && !out_ready);
   assign out_valid = valid_ff;
   assign word_out  = word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         word_ff <= word_in;
      end
   end

endmodule

// ===== src/rotary_encoder_debounce_counter_top.sv =====
// Channel  Dir  Word
// req_ch   in   req_type, pin_left, pin_right, pin_button, load_value
// rsp_ch   out  position_value, counts, step/press events, button_raw_pressed
// csr_ch   in   index 0..3, wdata (low limit, high limit, short wrap, long wrap)
//
// One word per cycle while rsp_ch takes results; the result appears in the cycle after its word is taken.
// The single result register lets the next word in while the last is taken.
// req_ch.ready drops only in reset or while a result is held and rsp_ch.ready is low.
// Synchronous reset clears state and counters; csr_ch and req_ch wait during reset.
module rotary_encoder_debounce_counter_top (
   input logic           clock,
   input logic           reset,
   rotenc_req_if.sink    req_ch,
   rotenc_rsp_if.source  rsp_ch,
   rotenc_csr_if.sink    csr_ch
);

   rotenc_pkg::cfg_type      cfg;
   rotenc_pkg::rsp_word_type word_next;
   rotenc_pkg::rsp_word_type word_out;
   logic                     accept;

   rotenc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (csr_ch.valid),
      .wr_index (csr_ch.index),
      .wr_data  (csr_ch.wdata),
      .wr_ready (csr_ch.ready),
      .cfg      (cfg)
   );

   rotenc_core u_core (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_type   (req_ch.req_type),
      .pin_left   (req_ch.pin_left),
      .pin_right  (req_ch.pin_right),
      .pin_button (req_ch.pin_button),
      .load_value (req_ch.load_value),
      .cfg        (cfg),
      .result     (word_next)
   );

   rotenc_out u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .word_in   (word_next),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .word_out  (word_out),
      .accept    (accept)
   );

   assign rsp_ch.position_value     = word_out.position_value;
   assign rsp_ch.short_press_count  = word_out.short_press_count;
   assign rsp_ch.long_press_count   = word_out.long_press_count;
   assign rsp_ch.step_event         = word_out.step_event;
   assign rsp_ch.short_press_event  = word_out.short_press_event;
   assign rsp_ch.long_press_event   = word_out.long_press_event;
   assign rsp_ch.button_raw_pressed = word_out.button_raw_pressed;

endmodule

// ===== src/rotenc_chk.sv =====
`include "assert_macros.svh"

module rotenc_chk (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                in_req_type,
   input logic                                in_pin_button,
   input logic signed [rotenc_pkg::POS_W-1:0] in_load_value,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [rotenc_pkg::POS_W-1:0] rsp_position_value,
   input logic [1:0]                          rsp_step_event,
   input logic                                rsp_short_press_event,
   input logic                                rsp_long_press_event,
   input logic                                rsp_button_raw_pressed
);

   logic                                req_fire;
   logic                                rsp_stall;
   logic                                load_fire;
   logic                                held_ok;
   logic                                raw_ok;
   logic                                load_ok;
   logic signed [rotenc_pkg::POS_W-1:0] last_pos_ff;
   logic signed [rotenc_pkg::POS_W-1:0] last_load_ff;
   logic                                last_button_ff;

   assign req_fire  = req_valid && req_ready;
   assign rsp_stall = rsp_valid && !rsp_ready;
   assign load_fire = req_fire && in_req_type;
   assign held_ok   = rsp_valid && (rsp_position_value == last_pos_ff);
   assign raw_ok    = rsp_button_raw_pressed == !last_button_ff;
   assign load_ok   = (rsp_step_event == rotenc_pkg::STEP_NONE) && !rsp_short_press_event &&
                      !rsp_long_press_event && (rsp_position_value == last_load_ff);

   // previous-cycle copies of the watched ports
   always_ff @(posedge clock) begin
      last_pos_ff    <= rsp_position_value;
      last_load_ff   <= in_load_value;
      last_button_ff <= in_pin_button;
   end

   `RC_ASSERT_NEXT(a_word_gives_result, req_fire, rsp_valid, "accepted word gave no result")
   `RC_ASSERT_NOW(a_no_overwrite, rsp_stall, !req_ready, "input taken over a stalled result")
   `RC_ASSERT_NEXT(a_stall_holds, rsp_stall, held_ok, "stalled result changed")
   `RC_ASSERT_NEXT(a_raw_button, req_fire, raw_ok, "raw button mismatch")
   `RC_ASSERT_NEXT(a_load_word, load_fire, load_ok, "load result wrong")

endmodule

bind rotary_encoder_debounce_counter_top rotenc_chk u_chk (
   .clock                  (clock),
   .reset                  (reset),
   .req_valid              (req_ch.valid),
   .req_ready              (req_ch.ready),
   .in_req_type            (req_ch.req_type),
   .in_pin_button          (req_ch.pin_button),
   .in_load_value          (req_ch.load_value),
   .rsp_valid              (rsp_ch.valid),
   .rsp_ready              (rsp_ch.ready),
   .rsp_position_value     (rsp_ch.position_value),
   .rsp_step_event         (rsp_ch.step_event),
   .rsp_short_press_event  (rsp_ch.short_press_event),
   .rsp_long_press_event   (rsp_ch.long_press_event),
   .rsp_button_raw_pressed (rsp_ch.button_raw_pressed)
);

// ===== tb/testbench.sv =====
module testbench;

   typedef struct packed {
      logic                               req_type;
      logic                               pin_left;
      logic                               pin_right;
      logic                               pin_button;
      logic signed [rotenc_pkg::POS_W-1:0] load_value;
   } req_word_type;

   class encoder_scoreboard;
      rotenc_pkg::cfg_type                 cfg;
      logic [rotenc_pkg::ROT_W-1:0]        rot_level;
      logic [rotenc_pkg::BTN_W-1:0]        btn_level;
      bit                                  detent_armed;
      bit                                  long_armed;
      logic signed [rotenc_pkg::POS_W-1:0] position;
      logic [rotenc_pkg::CNT_W-1:0]        short_count;
      logic [rotenc_pkg::CNT_W-1:0]        long_count;
      rotenc_pkg::rsp_word_type            due_words[$];
      int                                  fails;
      int                                  shown;
      int                                  n_results;
      int                                  n_up;
      int                                  n_down;
      int                                  n_blocked;
      int                                  n_short;
      int                                  n_long;

      function new();
         cfg.low_limit = '0;
         cfg.high_limit = '0;
         cfg.short_wrap = 8'd1;
         cfg.long_wrap = 8'd1;
         rot_level = '0;
         btn_level = '0;
         detent_armed = 0;
         long_armed = 0;
         position = '0;
         short_count = '0;
         long_count = '0;
      endfunction

      function int due_count();
         return due_words.size();
      endfunction

      function void set_reg(logic [rotenc_pkg::CSR_IDX_W-1:0] idx,
                            logic [rotenc_pkg::CSR_DATA_W-1:0] data);
         case (idx)
            rotenc_pkg::CSR_LOW_LIMIT:  cfg.low_limit = data;
            rotenc_pkg::CSR_HIGH_LIMIT: cfg.high_limit = data;
            rotenc_pkg::CSR_SHORT_WRAP: cfg.short_wrap = data[rotenc_pkg::CNT_W-1:0];
            rotenc_pkg::CSR_LONG_WRAP:  cfg.long_wrap = data[rotenc_pkg::CNT_W-1:0];
            default: ;
         endcase
      endfunction

      function void complain(string what, int want, int seen);
         fails++;
         if (shown < 10) begin
            shown++;
            $display("mismatch %s: expected %0d, got %0d", what, want, seen);
         end
      endfunction

      function void note_word(req_word_type w);
         rotenc_pkg::rsp_word_type want;
         bit                       pressed;
         pressed = !w.pin_button;
         want = '0;
         want.step_event = rotenc_pkg::STEP_NONE;
         if (w.req_type) begin
            position = w.load_value;
         end else begin
            if (!w.pin_left && rot_level < rotenc_pkg::ROT_MAX) rot_level++;
            else if (rot_level > 0) rot_level--;
            if (pressed) begin
               if (btn_level < rotenc_pkg::BTN_MAX) btn_level++;
            end else if (btn_level > 0) begin
               btn_level--;
            end
            if (rot_level > rotenc_pkg::ROT_MAX - 2 && !detent_armed) begin
               detent_armed = 1;
               if (!w.pin_right && position < cfg.high_limit) begin
                  position++;
                  want.step_event = rotenc_pkg::STEP_UP;
               end else if (w.pin_right && position > cfg.low_limit) begin
                  position--;
                  want.step_event = rotenc_pkg::STEP_DOWN;
               end else begin
                  want.step_event = rotenc_pkg::STEP_BLOCKED;
               end
            end
            if (rot_level == 0 && btn_level == 0) begin
               detent_armed = 0;
               long_armed = 0;
            end
            if (btn_level > rotenc_pkg::BTN_MAX - 2 && !long_armed) begin
               long_armed = 1;
               want.long_press_event = 1;
               long_count = (long_count < cfg.long_wrap) ? long_count + 1'b1 : '0;
            end
            // short press shares the detent flag
            if (btn_level > rotenc_pkg::ROT_MAX - 2 && !detent_armed) begin
               detent_armed = 1;
               want.short_press_event = 1;
               short_count = (short_count < cfg.short_wrap) ? short_count + 1'b1 : '0;
            end
         end
         want.position_value = position;
         want.short_press_count = short_count;
         want.long_press_count = long_count;
         want.button_raw_pressed = pressed;
         due_words.push_back(want);
      endfunction

      function void check_word(rotenc_pkg::rsp_word_type got);
         rotenc_pkg::rsp_word_type want;
         n_results++;
         case (got.step_event)
            rotenc_pkg::STEP_UP:      n_up++;
            rotenc_pkg::STEP_DOWN:    n_down++;
            rotenc_pkg::STEP_BLOCKED: n_blocked++;
            default: ;
         endcase
         if (got.short_press_event === 1'b1) n_short++;
         if (got.long_press_event === 1'b1) n_long++;
         if (due_words.size() == 0) begin
            complain("result word with none due, position", 0, int'(got.position_value));
            return;
         end
         want = due_words.pop_front();
         if (got.position_value !== want.position_value)
            complain("position_value", int'(want.position_value), int'(got.position_value));
         if (got.short_press_count !== want.short_press_count)
            complain("short_press_count", int'(want.short_press_count),
                     int'(got.short_press_count));
         if (got.long_press_count !== want.long_press_count)
            complain("long_press_count", int'(want.long_press_count),
                     int'(got.long_press_count));
         if (got.step_event !== want.step_event)
            complain("step_event", int'(want.step_event), int'(got.step_event));
         if (got.short_press_event !== want.short_press_event)
            complain("short_press_event", int'(want.short_press_event),
                     int'(got.short_press_event));
         if (got.long_press_event !== want.long_press_event)
            complain("long_press_event", int'(want.long_press_event),
                     int'(got.long_press_event));
         if (got.button_raw_pressed !== want.button_raw_pressed)
            complain("button_raw_pressed", int'(want.button_raw_pressed),
                     int'(got.button_raw_pressed));
      endfunction
   endclass

   logic clock;
   logic reset;

   rotenc_req_if req_ch();
   rotenc_rsp_if rsp_ch();
   rotenc_csr_if csr_ch();

   rotary_encoder_debounce_counter_top DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   encoder_scoreboard        board = new();
   rotenc_pkg::rsp_word_type seen_word;
   int                       words_sent;
   int                       settings_used;
   int                       send_idle_pct;
   int                       rsp_stall_pct;
   bit                       hold_request;
   int                       hold_left;
   int                       end_wait;

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("RESULT: ERROR");
      $finish;
   end

   // receiver: random stalls plus one long hold-off
   initial begin
      rsp_ch.ready = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_left = 400;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready = 0;
         end else begin
            rsp_ch.ready = ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         seen_word.position_value = rsp_ch.position_value;
         seen_word.short_press_count = rsp_ch.short_press_count;
         seen_word.long_press_count = rsp_ch.long_press_count;
         seen_word.step_event = rotenc_pkg::step_type'(rsp_ch.step_event);
         seen_word.short_press_event = rsp_ch.short_press_event;
         seen_word.long_press_event = rsp_ch.long_press_event;
         seen_word.button_raw_pressed = rsp_ch.button_raw_pressed;
         board.check_word(seen_word);
      end
   end

   function automatic logic jitter(logic v);
      return ($urandom_range(11) == 0) ? !v : v;
   endfunction

   function automatic logic [rotenc_pkg::POS_W-1:0] pick_position();
      int v;
      case ($urandom_range(3))
         0: v = int'(board.cfg.low_limit) + int'($urandom_range(4)) - 2;
         1: v = int'(board.cfg.high_limit) + int'($urandom_range(4)) - 2;
         2: v = $urandom_range(1) ? 32767 : -32768;
         default: v = $urandom;
      endcase
      return v[rotenc_pkg::POS_W-1:0];
   endfunction

   task automatic send_word(input logic ld, input logic left, input logic right,
                            input logic btn, input logic [rotenc_pkg::POS_W-1:0] value);
      req_word_type w;
      w.req_type = ld;
      w.pin_left = left;
      w.pin_right = right;
      w.pin_button = btn;
      w.load_value = value;
      @(negedge clock);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_ch.valid = 0;
         @(negedge clock);
      end
      req_ch.req_type = ld;
      req_ch.pin_left = left;
      req_ch.pin_right = right;
      req_ch.pin_button = btn;
      req_ch.load_value = value;
      req_ch.valid = 1;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      board.note_word(w);
      words_sent++;
   endtask

   task automatic tick(input logic left, input logic right, input logic btn);
      send_word(1'b0, left, right, btn, rotenc_pkg::POS_W'($urandom));
   endtask

   task automatic drain();
      @(negedge clock);
      req_ch.valid = 0;
      while (board.due_count() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [rotenc_pkg::CSR_IDX_W-1:0] idx,
                            input logic [rotenc_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_ch.index = idx;
      csr_ch.wdata = data;
      csr_ch.valid = 1;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      board.set_reg(idx, data);
      @(negedge clock);
      csr_ch.valid = 0;
   endtask

   task automatic write_all(input int lo, input int hi, input int sw, input int lw);
      drain();
      write_reg(rotenc_pkg::CSR_LOW_LIMIT, lo[rotenc_pkg::CSR_DATA_W-1:0]);
      write_reg(rotenc_pkg::CSR_HIGH_LIMIT, hi[rotenc_pkg::CSR_DATA_W-1:0]);
      write_reg(rotenc_pkg::CSR_SHORT_WRAP, sw[rotenc_pkg::CSR_DATA_W-1:0]);
      write_reg(rotenc_pkg::CSR_LONG_WRAP, lw[rotenc_pkg::CSR_DATA_W-1:0]);
      settings_used++;
   endtask

   // one burst of rotation and/or button activity followed by a release
   task automatic gesture(input bit use_rot, input bit use_btn, input bit clean);
      int span;
      int rest;
      bit dir;
      span = $urandom_range(14, 3);
      dir = 1'($urandom_range(1));
      for (int i = 0; i < span; i++)
         tick(use_rot ? jitter(1'b0) : 1'b1, ($urandom_range(15) == 0) ? !dir : dir,
              use_btn ? jitter(1'b0) : 1'b1);
      rest = clean ? span + $urandom_range(6, 2) : $urandom_range(span);
      for (int i = 0; i < rest; i++)
         tick(clean ? 1'b1 : jitter(1'b1), 1'($urandom_range(1)),
              clean ? 1'b1 : jitter(1'b1));
   endtask

   task automatic run_random(input int quota);
      int stop_at;
      int pick;
      stop_at = words_sent + quota;
      while (words_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 30) gesture(1, 0, 1);
         else if (pick < 55) gesture(0, 1, 1);
         else if (pick < 68) gesture(1, 1, 1);
         else if (pick < 80)
            send_word(1'b1, 1'($urandom_range(1)), 1'($urandom_range(1)),
                      1'($urandom_range(1)), pick_position());
         else if (pick < 90) gesture(1, 1'($urandom_range(1)), 0);
         else
            repeat ($urandom_range(8, 1))
               send_word($urandom_range(15) == 0, 1'($urandom_range(1)),
                         1'($urandom_range(1)), 1'($urandom_range(1)),
                         rotenc_pkg::POS_W'($urandom));
      end
   endtask

   task automatic run_phase(input int lo, input int hi, input int sw, input int lw,
                            input int idle_pct, input int stall_pct, input bit squeeze);
      write_all(lo, hi, sw, lw);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      if (squeeze) begin
         @(posedge clock);
         hold_request = 1;
      end
      run_random(250);
   endtask

   task automatic long_hold();
      repeat (rotenc_pkg::BTN_MAX + 3) tick(1'b1, 1'($urandom_range(1)), 1'b0);
      repeat (rotenc_pkg::BTN_MAX + 2) tick(1'b1, 1'($urandom_range(1)), 1'b1);
   endtask

   initial begin
      reset = 1;
      req_ch.valid = 0;
      req_ch.req_type = 0;
      req_ch.pin_left = 1;
      req_ch.pin_right = 1;
      req_ch.pin_button = 1;
      req_ch.load_value = '0;
      csr_ch.valid = 0;
      csr_ch.index = '0;
      csr_ch.wdata = '0;
      hold_request = 0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      words_sent = 0;
      settings_used = 1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: extreme loads, blocked step above the high limit, integrator
      // stepping down at its maximum, button press while the detent flag is armed
      send_word(1'b1, 1'b0, 1'b0, 1'b0, 16'h7fff);
      send_word(1'b1, 1'b1, 1'b1, 1'b1, 16'h8000);
      tick(1'b1, 1'b1, 1'b1);
      send_word(1'b1, 1'b1, 1'b0, 1'b1, 16'd100);
      repeat (8) tick(1'b0, 1'b0, 1'b1);
      repeat (4) tick(1'b0, 1'b1, 1'b0);
      repeat (8) tick(1'b1, 1'b1, 1'b1);

      // long presses: count up, then wrap with the limit lowered below the count
      write_all(-32768, 32767, 255, 1);
      long_hold();
      drain();
      write_reg(rotenc_pkg::CSR_LONG_WRAP, 16'd0);
      long_hold();

      run_phase(-32768, 32767, 255, 255, 0, 0, 0);
      run_phase(-3, 3, 0, 0, 86, 0, 0);
      run_phase(5, -5, 3, 2, 0, 86, 1);
      run_phase(0, 0, 1, 1, 19, 19, 0);
      run_phase(-32768, -32760, 7, 0, 0, 0, 0);
      run_phase(int'($urandom_range(200)) - 100, int'($urandom_range(200)) - 100,
                $urandom_range(255), $urandom_range(255), 19, 19, 0);
      run_phase(32760, 32767, 2, 255, 86, 86, 0);

      @(negedge clock);
      req_ch.valid = 0;
      end_wait = 0;
      while (board.due_count() != 0 && end_wait < 5000) begin
         @(posedge clock);
         end_wait++;
      end
      repeat (4) @(posedge clock);
      if (board.due_count() != 0)
         board.complain("result words never delivered", board.due_count(), 0);

      $display("Sent %0d words under %0d register settings, checked %0d results.",
               words_sent, settings_used, board.n_results);
      $display("Seen: %0d up, %0d down, %0d blocked steps; %0d short, %0d long presses.",
               board.n_up, board.n_down, board.n_blocked, board.n_short, board.n_long);
      if (board.fails == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
